@@ rtl/ubxpp_pkg.sv @@
`default_nettype none

package ubxpp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam int PAYLOAD_BYTES = 24;
    localparam int WORD_COUNT    = 6;
    localparam int INDEX_W       = 5;
    localparam int WORD_SEL_W    = 3;

    localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(PAYLOAD_BYTES - 1);

    // Configuration register indexes.
    localparam logic [1:0] REG_CLASS = 2'd0;
    localparam logic [1:0] REG_ID    = 2'd1;
    localparam logic [1:0] REG_SKIP  = 2'd2;

    localparam logic [7:0] CLASS_RESET = 8'h01;
    localparam logic [7:0] ID_RESET    = 8'h02;
    localparam logic [7:0] SKIP_RESET  = 8'd6;

    typedef struct packed {
        logic signed [31:0] longitude;
        logic signed [31:0] latitude;
        logic signed [31:0] ellipsoid_height;
        logic signed [31:0] sea_level_height;
        logic [31:0]        horizontal_accuracy;
        logic [31:0]        vertical_accuracy;
    } pos_result_t;

endpackage

`default_nettype wire

@@ rtl/ubxpp_in_reg.sv @@
`default_nettype none

module ubxpp_in_reg (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rx_valid,
    output logic            rx_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       take,
    output logic            stage_valid,
    output logic [7:0]      stage_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    // A new transaction enters whenever the held byte is empty or leaves now.
    assign rx_ready   = !valid_reg || take;
    assign load       = rx_valid && rx_ready;
    assign valid_next = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_byte  = byte_reg;

endmodule

`default_nettype wire

@@ rtl/ubxpp_parser.sv @@
`default_nettype none

module ubxpp_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [7:0]         cfg_data,
    input  wire logic               step,
    input  wire logic [7:0]         rx_byte,
    output logic                    emit,
    output ubxpp_pkg::pos_result_t  result
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_CLASS   = 3'd2,
        PH_ID      = 3'd3,
        PH_SKIP    = 3'd4,
        PH_CAPTURE = 3'd5
    } phase_t;

    phase_t                              phase_reg;
    phase_t                              phase_next;
    logic [7:0]                          skip_reg;
    logic [7:0]                          skip_next;
    logic [ubxpp_pkg::INDEX_W-1:0]       index_reg;
    logic [ubxpp_pkg::INDEX_W-1:0]       index_next;
    logic [7:0]                          class_reg;
    logic [7:0]                          id_reg;
    logic [7:0]                          skip_count_reg;
    logic [31:0]                         words_reg [ubxpp_pkg::WORD_COUNT];
    logic                                word_we;
    logic [ubxpp_pkg::WORD_SEL_W-1:0]    word_sel;
    logic [1:0]                          lane;

    assign word_sel = index_reg[ubxpp_pkg::INDEX_W-1:2];
    assign lane     = index_reg[1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg      <= ubxpp_pkg::CLASS_RESET;
            id_reg         <= ubxpp_pkg::ID_RESET;
            skip_count_reg <= ubxpp_pkg::SKIP_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                ubxpp_pkg::REG_CLASS: class_reg      <= cfg_data;
                ubxpp_pkg::REG_ID:    id_reg         <= cfg_data;
                ubxpp_pkg::REG_SKIP:  skip_count_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        skip_next  = skip_reg;
        index_next = index_reg;
        word_we    = 1'b0;
        if (step)
        begin
            case (phase_reg)
                PH_SYNC2:
                begin
                    phase_next = (rx_byte == ubxpp_pkg::SYNC_SECOND) ? PH_CLASS : PH_HUNT;
                end
                PH_CLASS:
                begin
                    phase_next = (rx_byte == class_reg) ? PH_ID : PH_HUNT;
                end
                PH_ID:
                begin
                    if (rx_byte == id_reg)
                    begin
                        skip_next  = skip_count_reg;
                        index_next = '0;
                        phase_next = (skip_count_reg == 8'd0) ? PH_CAPTURE : PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_reg - 8'd1;
                    if (skip_reg == 8'd1)
                    begin
                        phase_next = PH_CAPTURE;
                        index_next = '0;
                    end
                end
                PH_CAPTURE:
                begin
                    word_we = 1'b1;
                    if (index_reg == ubxpp_pkg::LAST_INDEX)
                    begin
                        index_next = '0;
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        index_next = index_reg + ubxpp_pkg::INDEX_W'(1);
                    end
                end
                default:
                begin
                    phase_next = (rx_byte == ubxpp_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            skip_reg  <= 8'd0;
            index_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            index_reg <= index_next;
        end
    end

    // Payload bytes arrive little-endian: the low index bits pick the byte lane.
    always_ff @(posedge clk)
    begin
        if (word_we && (word_sel < ubxpp_pkg::WORD_SEL_W'(ubxpp_pkg::WORD_COUNT)))
        begin
            words_reg[word_sel][8*lane +: 8] <= rx_byte;
        end
    end

    // The last payload byte completes the top lane of the last word, so it is
    // merged here rather than read back from the word store.
    assign emit = (phase_reg == PH_CAPTURE) && (index_reg == ubxpp_pkg::LAST_INDEX);

    always_comb
    begin
        result.longitude           = words_reg[0];
        result.latitude            = words_reg[1];
        result.ellipsoid_height    = words_reg[2];
        result.sea_level_height    = words_reg[3];
        result.horizontal_accuracy = words_reg[4];
        result.vertical_accuracy   = {rx_byte, words_reg[ubxpp_pkg::WORD_COUNT-1][23:0]};
    end

`ifndef SYNTHESIS
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        index_reg <= ubxpp_pkg::LAST_INDEX)
        else $error("payload index out of range");

    a_emit_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        step && emit |=> phase_reg == PH_HUNT && index_reg == '0)
        else $error("parser did not return to hunt after a frame");

    a_skip_ends_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_SKIP && skip_reg == 8'd1
        |=> phase_reg == PH_CAPTURE && index_reg == '0)
        else $error("skip did not end in capture");
`endif

endmodule

`default_nettype wire

@@ rtl/ubxpp_out_reg.sv @@
`default_nettype none

module ubxpp_out_reg (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire ubxpp_pkg::pos_result_t result,
    output logic                        free,
    output logic                        pos_valid,
    input  wire logic                   pos_ready,
    output ubxpp_pkg::pos_result_t      pos_data
);

    logic                   valid_reg;
    logic                   valid_next;
    ubxpp_pkg::pos_result_t data_reg;

    assign free       = !valid_reg || pos_ready;
    assign valid_next = load || (valid_reg && !pos_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign pos_valid = valid_reg;
    assign pos_data  = data_reg;

endmodule

`default_nettype wire

@@ rtl/ubx_position_frame_parser_unit.sv @@
// A result enters the output register when the stage passes on the last payload byte, which
// is first held in the input register. Throughput: one byte per cycle; the parse stage
// between the input register and the result register sets that figure.
// The byte stream stalls only while a finished result waits in the output register.
// Reset (rst_n, asynchronous, active low) returns the parser to the sync hunt, empties both
// registers and loads the default class, id and skip count.
`default_nettype none

module ubx_position_frame_parser_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        rx_valid,
    output logic             rx_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             pos_valid,
    input  wire logic        pos_ready,
    output logic signed [31:0] longitude,
    output logic signed [31:0] latitude,
    output logic signed [31:0] ellipsoid_height,
    output logic signed [31:0] sea_level_height,
    output logic [31:0]      horizontal_accuracy,
    output logic [31:0]      vertical_accuracy
);

    logic                   stage_valid;
    logic                   stage_take;
    logic [7:0]             stage_byte;
    logic                   emit;
    logic                   out_free;
    ubxpp_pkg::pos_result_t result;
    ubxpp_pkg::pos_result_t pos_data;

    // A byte that completes a frame may only leave the stage when the result slot is free.
    assign stage_take = stage_valid && (!emit || out_free);

    ubxpp_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_ready    (rx_ready),
        .rx_byte     (rx_byte),
        .take        (stage_take),
        .stage_valid (stage_valid),
        .stage_byte  (stage_byte)
    );

    ubxpp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .step         (stage_take),
        .rx_byte      (stage_byte),
        .emit         (emit),
        .result       (result)
    );

    ubxpp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (stage_take && emit),
        .result    (result),
        .free      (out_free),
        .pos_valid (pos_valid),
        .pos_ready (pos_ready),
        .pos_data  (pos_data)
    );

    assign longitude           = pos_data.longitude;
    assign latitude            = pos_data.latitude;
    assign ellipsoid_height    = pos_data.ellipsoid_height;
    assign sea_level_height    = pos_data.sea_level_height;
    assign horizontal_accuracy = pos_data.horizontal_accuracy;
    assign vertical_accuracy   = pos_data.vertical_accuracy;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        stage_take && emit |-> !pos_valid || pos_ready)
        else $error("result register overwritten while still held");

    a_stall_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid && emit && pos_valid && !pos_ready |-> !rx_ready)
        else $error("input accepted while the frame end is stalled");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        stage_take && emit |=> pos_valid)
        else $error("completed frame did not reach the output");
`endif

endmodule

`default_nettype wire
